### hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int GAIN_WIDTH = 32;
  localparam int GAIN_FRAC  = 24;

  // radix-16 multiplier: one gain digit per step
  localparam int DIGIT = 4;
  localparam int STEPS = GAIN_WIDTH / DIGIT;
  localparam int CNT_W = $clog2(STEPS);

  // |y - u| bound: error magnitude grown by the gain's integer bits, plus limits
  localparam int MAG_W  = DATA_WIDTH + GAIN_WIDTH - GAIN_FRAC + 2;
  localparam int PROD_W = MAG_W + GAIN_WIDTH;
  localparam int R_W    = PROD_W - GAIN_FRAC + 1;
  localparam int WIDE_W = MAG_W + GAIN_WIDTH - GAIN_FRAC + 3;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_DT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KB_DT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;

  localparam logic [GAIN_WIDTH-1:0] P_GAIN_RST  = GAIN_WIDTH'(83886);
  localparam logic [GAIN_WIDTH-1:0] KI_DT_RST   = GAIN_WIDTH'(1007);
  localparam logic [GAIN_WIDTH-1:0] KB_DT_RST   = GAIN_WIDTH'(252);
  localparam logic [DATA_WIDTH-1:0] OUT_MAX_RST = DATA_WIDTH'(327680);
  localparam logic [DATA_WIDTH-1:0] OUT_MIN_RST = DATA_WIDTH'(-327680);

endpackage

### hw/rtl/pi_speed_controller_backcalc_core.sv
`timescale 1ns / 1ps
// PI speed controller with back-calculation anti-windup, Q16.16 data, Q8.24 gains.
// One word at a time: a new input word is accepted only after the previous result
// has been placed in the output register; the work is two 8-step passes of the
// radix-16 shift-add multiplier and the add/clamp steps between them.
// Reset (rst, synchronous): integral cleared, gains and limits to defaults.

module pi_speed_controller_backcalc_core
  import psc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [2*DATA_WIDTH-1:0] s_tdata,   // ref_speed, fb_speed
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [DATA_WIDTH-1:0]   m_tdata,   // drive
  output logic [0:0]              m_tuser,   // saturated
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_WIDTH-1:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_PI_GO  = 4'd2;
  localparam logic [3:0] S_PI_RUN = 4'd3;
  localparam logic [3:0] S_PI_RND = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_CLAMP  = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_KB_GO  = 4'd8;
  localparam logic [3:0] S_KB_RUN = 4'd9;
  localparam logic [3:0] S_KB_RND = 4'd10;
  localparam logic [3:0] S_UPD    = 4'd11;
  localparam logic [3:0] S_INT    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  localparam logic signed [WIDE_W-1:0] I_MAX =
    {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] I_MIN =
    {{(WIDE_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic [3:0]                   state;
  logic [3:0]                   state_next;

  logic [GAIN_WIDTH-1:0]        p_gain;
  logic [GAIN_WIDTH-1:0]        ki_dt;
  logic [GAIN_WIDTH-1:0]        kb_dt;
  logic [DATA_WIDTH-1:0]        out_max;
  logic [DATA_WIDTH-1:0]        out_min;
  logic [DATA_WIDTH-1:0]        integral;

  logic [DATA_WIDTH-1:0]        in_ref;
  logic [DATA_WIDTH-1:0]        in_fb;
  logic signed [DATA_WIDTH:0]   e;
  logic [DATA_WIDTH:0]          e_mag;
  logic [R_W-1:0]               rp;
  logic [R_W-1:0]               ri;
  logic [R_W-1:0]               rb;
  logic signed [WIDE_W-1:0]     u;
  logic signed [WIDE_W-1:0]     it;
  logic signed [WIDE_W-1:0]     d;
  logic [WIDE_W-1:0]            d_abs;
  logic signed [WIDE_W-1:0]     upd;
  logic signed [WIDE_W-1:0]     acc;
  logic [DATA_WIDTH-1:0]        y;
  logic                         sat;

  logic signed [WIDE_W-1:0]     integral_w;
  logic signed [WIDE_W-1:0]     max_w;
  logic signed [WIDE_W-1:0]     min_w;
  logic signed [WIDE_W-1:0]     y_w;
  logic signed [WIDE_W-1:0]     rp_w;
  logic signed [WIDE_W-1:0]     ri_w;
  logic signed [WIDE_W-1:0]     rb_w;

  logic                         start_a;
  logic                         start_b;
  logic [MAG_W-1:0]             mag_a;
  logic [MAG_W-1:0]             mag_e;
  logic [GAIN_WIDTH-1:0]        gain_a;
  logic                         done_a;
  logic                         done_b;
  logic [PROD_W-1:0]            prod_a;
  logic [PROD_W-1:0]            prod_b;
  logic                         out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign e_mag = e[DATA_WIDTH] ? (DATA_WIDTH+1)'(0) - e : e;
  assign mag_e = {{(MAG_W-DATA_WIDTH-1){1'b0}}, e_mag};
  assign d_abs = d[WIDE_W-1] ? WIDE_W'(0) - d : d;

  assign integral_w = {{(WIDE_W-DATA_WIDTH){integral[DATA_WIDTH-1]}}, integral};
  assign max_w      = {{(WIDE_W-DATA_WIDTH){out_max[DATA_WIDTH-1]}}, out_max};
  assign min_w      = {{(WIDE_W-DATA_WIDTH){out_min[DATA_WIDTH-1]}}, out_min};
  assign y_w        = {{(WIDE_W-DATA_WIDTH){y[DATA_WIDTH-1]}}, y};
  assign rp_w       = {{(WIDE_W-R_W){1'b0}}, rp};
  assign ri_w       = {{(WIDE_W-R_W){1'b0}}, ri};
  assign rb_w       = {{(WIDE_W-R_W){1'b0}}, rb};
  assign acc        = integral_w + upd;

  assign start_a = (state == S_PI_GO) || (state == S_KB_GO);
  assign start_b = (state == S_PI_GO);
  assign mag_a   = (state == S_PI_GO) ? mag_e : d_abs[MAG_W-1:0];
  assign gain_a  = (state == S_PI_GO) ? p_gain : kb_dt;

  psc_mul u_mul_a (
    .clk   (clk),
    .rst   (rst),
    .start (start_a),
    .mag   (mag_a),
    .gain  (gain_a),
    .done  (done_a),
    .prod  (prod_a)
  );

  psc_mul u_mul_b (
    .clk   (clk),
    .rst   (rst),
    .start (start_b),
    .mag   (mag_e),
    .gain  (ki_dt),
    .done  (done_b),
    .prod  (prod_b)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_ERR;
      S_ERR:    state_next = S_PI_GO;
      S_PI_GO:  state_next = S_PI_RUN;
      S_PI_RUN: if (done_a && done_b) state_next = S_PI_RND;
      S_PI_RND: state_next = S_SUM;
      S_SUM:    state_next = S_CLAMP;
      S_CLAMP:  state_next = S_DIFF;
      S_DIFF:   state_next = S_KB_GO;
      S_KB_GO:  state_next = S_KB_RUN;
      S_KB_RUN: if (done_a) state_next = S_KB_RND;
      S_KB_RND: state_next = S_UPD;
      S_UPD:    state_next = S_INT;
      S_INT:    state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      integral <= '0;
      m_tvalid <= 1'b0;
      p_gain   <= P_GAIN_RST;
      ki_dt    <= KI_DT_RST;
      kb_dt    <= KB_DT_RST;
      out_max  <= OUT_MAX_RST;
      out_min  <= OUT_MIN_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_P_GAIN:  p_gain  <= cfg_wdata;
          REG_KI_DT:   ki_dt   <= cfg_wdata;
          REG_KB_DT:   kb_dt   <= cfg_wdata;
          REG_OUT_MAX: out_max <= cfg_wdata[DATA_WIDTH-1:0];
          REG_OUT_MIN: out_min <= cfg_wdata[DATA_WIDTH-1:0];
          default: ;
        endcase
      end
      if (state == S_INT) begin
        if (acc > I_MAX) begin
          integral <= I_MAX[DATA_WIDTH-1:0];
        end else if (acc < I_MIN) begin
          integral <= I_MIN[DATA_WIDTH-1:0];
        end else begin
          integral <= acc[DATA_WIDTH-1:0];
        end
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      in_ref <= s_tdata[DATA_WIDTH-1:0];
      in_fb  <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    end
    if (state == S_ERR) begin
      e <= {in_ref[DATA_WIDTH-1], in_ref} - {in_fb[DATA_WIDTH-1], in_fb};
    end
    // round half away from zero on the magnitude
    if (state == S_PI_RND) begin
      rp <= {1'b0, prod_a[PROD_W-1:GAIN_FRAC]} + R_W'(prod_a[GAIN_FRAC-1]);
      ri <= {1'b0, prod_b[PROD_W-1:GAIN_FRAC]} + R_W'(prod_b[GAIN_FRAC-1]);
    end
    if (state == S_SUM) begin
      u  <= e[DATA_WIDTH] ? integral_w - rp_w : integral_w + rp_w;
      it <= e[DATA_WIDTH] ? WIDE_W'(0) - ri_w : ri_w;
    end
    if (state == S_CLAMP) begin
      if (u > max_w) begin
        y   <= out_max;
        sat <= 1'b1;
      end else if (u < min_w) begin
        y   <= out_min;
        sat <= 1'b1;
      end else begin
        y   <= u[DATA_WIDTH-1:0];
        sat <= 1'b0;
      end
    end
    if (state == S_DIFF) begin
      d <= y_w - u;
    end
    if (state == S_KB_RND) begin
      rb <= {1'b0, prod_a[PROD_W-1:GAIN_FRAC]} + R_W'(prod_a[GAIN_FRAC-1]);
    end
    if (state == S_UPD) begin
      upd <= d[WIDE_W-1] ? it - rb_w : it + rb_w;
    end
    if (state == S_OUT && out_free) begin
      m_tdata    <= y;
      m_tuser[0] <= sat;
    end
  end

endmodule

### hw/rtl/psc_mul.sv
`timescale 1ns / 1ps

module psc_mul
  import psc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [MAG_W-1:0]      mag,
  input  logic [GAIN_WIDTH-1:0] gain,
  output logic                  done,
  output logic [PROD_W-1:0]     prod
);

  logic                     run;
  logic [CNT_W-1:0]         cnt;
  logic [MAG_W-1:0]         mcand;
  logic [MAG_W-1:0]         hi;
  logic [GAIN_WIDTH-1:0]    lo;
  logic [MAG_W+DIGIT-1:0]   partial;
  logic [MAG_W+DIGIT-1:0]   sum;

  assign partial = (MAG_W+DIGIT)'(mcand) * (MAG_W+DIGIT)'(lo[DIGIT-1:0]);
  assign sum     = (MAG_W+DIGIT)'(hi) + partial;
  assign done    = run && (cnt == CNT_W'(STEPS-1));
  assign prod    = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + CNT_W'(1);
      if (done) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= mag;
      hi    <= '0;
      lo    <= gain;
    end else if (run) begin
      hi <= sum[MAG_W+DIGIT-1:DIGIT];
      lo <= {sum[DIGIT-1:0], lo[GAIN_WIDTH-1:DIGIT]};
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import psc_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 75;
  localparam int DIR_ROWS    = 14;

  localparam longint WIDE_LIM = 64'sd1 <<< 60;
  localparam longint D_MAX    = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint D_MIN    = -D_MAX - 1;

  localparam logic [DATA_WIDTH-1:0] SPD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SPD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_FRAC;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] drive;
    logic                  sat;
  } drive_word_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] setpt;
    logic [DATA_WIDTH-1:0] meas;
    logic                  typed;
    logic [DATA_WIDTH-1:0] drive;
    logic                  sat;
  } stim_row_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] p;
    logic [GAIN_WIDTH-1:0] ki;
    logic [GAIN_WIDTH-1:0] kb;
    logic [DATA_WIDTH-1:0] omax;
    logic [DATA_WIDTH-1:0] omin;
  } gain_set_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [2*DATA_WIDTH-1:0] s_tdata;   // ref_speed, fb_speed
  logic                    m_tvalid;
  logic                    m_tready;
  logic [DATA_WIDTH-1:0]   m_tdata;   // drive
  logic [0:0]              m_tuser;   // saturated
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [GAIN_WIDTH-1:0]   cfg_wdata;

  pi_speed_controller_backcalc_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [GAIN_WIDTH-1:0] p_gain_m, ki_dt_m, kb_dt_m;
  logic [DATA_WIDTH-1:0] out_max_m, out_min_m;
  longint                integ_m;

  drive_word_t drive_q[$];
  int          errors = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_sat = 0;
  int          n_cfg = 0;
  bit          hold_req = 1'b0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  logic [DATA_WIDTH-1:0] base_sp = '0;
  logic [DATA_WIDTH-1:0] base_err = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // value times Q8.24 gain, nearest with ties away from zero, bounded to +-2^60
  function automatic longint gain_mul(longint a, logic [GAIN_WIDTH-1:0] g);
    logic [127:0] mag;
    logic [127:0] prod;
    mag = (a < 0) ? 128'(-a) : 128'(a);
    prod = (mag * 128'(g) + (128'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (prod > 128'(WIDE_LIM)) prod = 128'(WIDE_LIM);
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clamp_to(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic drive_word_t control_step(logic [DATA_WIDTH-1:0] setpt,
                                               logic [DATA_WIDTH-1:0] meas);
    drive_word_t w;
    longint err, u, y, upd, lim_hi, lim_lo;
    err = longint'(signed'(setpt)) - longint'(signed'(meas));
    u = clamp_to(gain_mul(err, p_gain_m) + integ_m, -WIDE_LIM, WIDE_LIM);
    lim_hi = longint'(signed'(out_max_m));
    lim_lo = longint'(signed'(out_min_m));
    w.sat = 1'b1;
    // upper limit wins when the limits are inverted
    if (u > lim_hi) y = lim_hi;
    else if (u < lim_lo) y = lim_lo;
    else begin
      y = u;
      w.sat = 1'b0;
    end
    upd = clamp_to(gain_mul(y - u, kb_dt_m) + gain_mul(err, ki_dt_m), -WIDE_LIM, WIDE_LIM);
    integ_m = clamp_to(integ_m + upd, D_MIN, D_MAX);
    w.drive = y[DATA_WIDTH-1:0];
    return w;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] corner_speed();
    case ($urandom_range(0, 4))
      0: return SPD_MAX;
      1: return SPD_MIN;
      2: return '0;
      3: return '1;
      default: return DATA_WIDTH'(1);
    endcase
  endfunction

  // mostly a loop tracking a held setpoint with a persistent error, some noise
  task automatic pick_speeds(output logic [DATA_WIDTH-1:0] sp, output logic [DATA_WIDTH-1:0] ms);
    int k;
    if ($urandom_range(0, 15) == 0) begin
      base_sp = $urandom() >> $urandom_range(0, 20);
      if ($urandom_range(0, 1)) base_sp = -base_sp;
      base_err = $urandom() >> $urandom_range(6, 31);
      if ($urandom_range(0, 1)) base_err = -base_err;
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      sp = base_sp + DATA_WIDTH'($urandom_range(0, 255)) - DATA_WIDTH'(128);
      ms = sp - base_err + DATA_WIDTH'($urandom_range(0, 63)) - DATA_WIDTH'(32);
    end else if (k < 8) begin
      sp = $urandom();
      ms = $urandom();
    end else begin
      sp = corner_speed();
      ms = corner_speed();
    end
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_P_GAIN:  p_gain_m = val;
      REG_KI_DT:   ki_dt_m = val;
      REG_KB_DT:   kb_dt_m = val;
      REG_OUT_MAX: out_max_m = val[DATA_WIDTH-1:0];
      REG_OUT_MIN: out_min_m = val[DATA_WIDTH-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic apply_set(gain_set_t s);
    reg_write(REG_P_GAIN, s.p);
    reg_write(REG_KI_DT, s.ki);
    reg_write(REG_KB_DT, s.kb);
    reg_write(REG_OUT_MAX, s.omax);
    reg_write(REG_OUT_MIN, s.omin);
    // unmapped indexes must leave everything alone
    for (int i = REG_OUT_MIN + 1; i < 2 ** CFG_IDX_W; i++)
      reg_write(CFG_IDX_W'(i), $urandom());
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic [DATA_WIDTH-1:0] setpt, logic [DATA_WIDTH-1:0] meas);
    int gap;
    if ($urandom_range(0, 23) == 0) send_idle = !send_idle;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {meas, setpt};
    do @(posedge clk); while (!s_tready);
    n_in++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stim
    stim_row_t             rows [DIR_ROWS];
    gain_set_t             sets [PHASES];
    drive_word_t           w;
    logic [DATA_WIDTH-1:0] sp, ms;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_P_GAIN;
    cfg_wdata <= '0;
    p_gain_m = P_GAIN_RST;
    ki_dt_m = KI_DT_RST;
    kb_dt_m = KB_DT_RST;
    out_max_m = OUT_MAX_RST;
    out_min_m = OUT_MIN_RST;
    integ_m = 0;

    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{SPD_MAX,       SPD_MIN,       1'b1, OUT_MAX_RST,   1'b1},
      '{SPD_MIN,       SPD_MAX,       1'b1, OUT_MIN_RST,   1'b1},
      '{SPD_MAX,       SPD_MAX,       1'b0, 32'h0,         1'b0},
      '{SPD_MIN,       SPD_MIN,       1'b0, 32'h0,         1'b0},
      '{32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0,         1'b0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0,         1'b0},
      '{32'h0005_0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{32'h0064_0000, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{32'h0064_0000, 32'h0032_0000, 1'b0, 32'h0,         1'b0},
      '{32'h0000_0000, 32'h0064_0000, 1'b0, 32'h0,         1'b0}
    };

    sets[0] = '{32'd0, 32'd0, 32'd0, SPD_MAX, SPD_MIN};
    sets[1] = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, SPD_MAX, SPD_MIN};   // integral saturates
    sets[2] = '{P_GAIN_RST, KI_DT_RST, KB_DT_RST, OUT_MIN_RST, OUT_MAX_RST};   // inverted
    sets[3] = '{GAIN_ONE, GAIN_ONE >> 4, GAIN_ONE >> 2, OUT_MAX_RST, OUT_MIN_RST};
    sets[4] = '{P_GAIN_RST, KI_DT_RST, KB_DT_RST, 32'd0, 32'd0};
    sets[5] = '{GAIN_MAX, GAIN_ONE, 32'd0, SPD_MIN, SPD_MAX};
    for (int ph = 6; ph < PHASES; ph++) begin
      sets[ph].p = $urandom() >> $urandom_range(0, 31);
      sets[ph].ki = $urandom() >> $urandom_range(4, 31);
      sets[ph].kb = $urandom() >> $urandom_range(4, 31);
      if ($urandom_range(0, 3) == 0) begin
        sets[ph].omax = $urandom();
        sets[ph].omin = $urandom();
      end else begin
        sets[ph].omax = $urandom() >> $urandom_range(1, 31);
        sets[ph].omin = -($urandom() >> $urandom_range(1, 31));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].setpt, rows[i].meas);
      w = control_step(rows[i].setpt, rows[i].meas);
      if (rows[i].typed) begin
        w.drive = rows[i].drive;
        w.sat = rows[i].sat;
      end
      drive_q.push_back(w);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      apply_set(sets[ph]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 3 && k == 10) hold_req = 1'b1;
        pick_speeds(sp, ms);
        send_word(sp, ms);
        drive_q.push_back(control_step(sp, ms));
      end
    end

    wait_idle();
    errors += drive_q.size();
    $display("Sent %0d speed words under %0d gain/limit settings, %0d register writes.",
             n_in, PHASES + 1, n_cfg);
    $display("Received %0d drive words, %0d clamped, %0d errors.", n_out, n_sat, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : drain_side
    drive_word_t got, want;
    int          stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 23) == 0) recv_idle = !recv_idle;
      stall = recv_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.drive = m_tdata;
      got.sat = m_tuser[0];
      n_out++;
      if (got.sat) n_sat++;
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("word %0d unexpected: drive %h sat %b", n_out, got.drive, got.sat);
      end else begin
        want = drive_q.pop_front();
        if (got.drive !== want.drive || got.sat !== want.sat) begin
          errors++;
          if (errors <= 10)
            $display("word %0d: drive exp %h got %h, sat exp %b got %b",
                     n_out, want.drive, got.drive, want.sat, got.sat);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
